### sv/mut_pkg.sv
// ----------------------------------------------------------------------------
// mut_pkg: shared types and constants of the Maurer universal test accumulator
// Widths of block patterns, block numbers and the log2 format, the event that
// travels from the front end to the back end, and the log2 fraction table.
// ----------------------------------------------------------------------------
package mut_pkg;

    // Field and register widths
    localparam int BYTE_BITS         = 8;
    localparam int BYTE_TOP          = 7;
    localparam int BYTE_IDX_W        = 3;
    localparam int LEFT_W            = $clog2(BYTE_BITS + 1);
    localparam int LEN_W             = 5;
    localparam int INIT_W            = 20;
    localparam int TEST_W            = 27;
    localparam int SUM_BITS          = 48;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 27;
    localparam int OUT_TDATA_W       = 80;

    // Block and index geometry
    localparam int MIN_BLOCK_BITS    = 6;
    localparam int MAX_BLOCK_BITS    = 16;
    localparam int SEEN_DEPTH        = 1 << MAX_BLOCK_BITS;
    localparam int INDEX_BITS        = 28;
    localparam int POS_W             = $clog2(INDEX_BITS);

    // Fixed-point log2 format
    localparam int LOG_FRACTION_BITS = 16;
    localparam int LOG_TABLE_BITS    = 10;
    localparam int LOG_TAB_SIZE      = 1 << LOG_TABLE_BITS;
    localparam int LOG_W             = POS_W + LOG_FRACTION_BITS;

    // Sequence tag kept with each last-seen entry
    localparam int EPOCH_BITS        = 8;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_BITS  = 2'd0,
        REG_INIT_BLOCKS = 2'd1,
        REG_TEST_BLOCKS = 2'd2
    } t_cfg_reg;

    typedef logic [MAX_BLOCK_BITS-1:0] t_pattern;
    typedef logic [INDEX_BITS-1:0]     t_index;

    typedef struct packed {
        logic test;
        logic last;
        logic restart;
    } t_flags;

    typedef struct packed {
        t_pattern pat;
        t_index   cur;
        t_flags   flags;
    } t_event;

    typedef struct packed {
        logic [EPOCH_BITS-1:0] epoch;
        t_index                idx;
    } t_seen;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [INIT_W-1:0] init;
        t_index            last_index;
    } t_run_cfg;

    // Fraction bits of log2(1 + i / LOG_TAB_SIZE) by repeated squaring in Q1.30.
    // Only ever evaluated with constant arguments while building the table.
    function automatic logic [LOG_FRACTION_BITS-1:0] frac_entry(input int unsigned i);
        logic [63:0]                  x;
        logic [LOG_FRACTION_BITS-1:0] r;
        logic                         b;
        x = 64'(LOG_TAB_SIZE + i) << (30 - LOG_TABLE_BITS);
        r = '0;
        for (int k = 0; k < LOG_FRACTION_BITS; k++) begin
            x = (x * x) >> 30;
            b = (x >= 64'h0000_0000_8000_0000);
            r = {r[LOG_FRACTION_BITS-2:0], b};
            if (b) begin
                x = x >> 1;
            end
        end
        return r;
    endfunction

endpackage

### sv/maurer_universal_test_accumulator.sv
// ----------------------------------------------------------------------------
// maurer_universal_test_accumulator: accumulation part of Maurer's universal test
// Cuts a byte stream into L-bit blocks, keeps the last block number of every
// pattern and sums fixed-point log2 distances over the test blocks.
// ----------------------------------------------------------------------------
// The sequence arrives one byte per transaction on the slave stream, most
// significant bit first, with tuser set on the byte that starts a new
// sequence. The front end reports the first block that a byte completes and
// holds the byte until a second one (six- and seven-bit blocks) is reported
// too; this walk over the held byte and a full queue set the input rate. The
// back end handles one block per cycle, unless a waiting result or a clearing
// pass holds it, through a read-modify-write of the 65536-entry last-seen
// memory, with five pipeline stages from the read to the sum.
// The result of a sequence is formed from the event of block Q+K.
// A queue of block events lets the two halves stall independently, and the
// result waits in an output register while input keeps flowing; only a second
// result reaching that register before the first is taken halts the pipeline.
// After reset, and again when the sequence tags of the memory entries run out
// (on the 256th new sequence and on every 255th one after that), a clearing
// pass over all 65536 entries rewrites the memory while the input stream is
// held off; configuration writes are taken at any time but should only be
// made while the block is idle.
// ----------------------------------------------------------------------------
module maurer_universal_test_accumulator import mut_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration writes
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Byte stream in
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [BYTE_BITS-1:0]   s_axis_tdata,  // [7:0] data_byte
    input  logic                   s_axis_tuser,  // [0] first
    // Result out
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [47:0] log_sum, [74:48] blocks_tested
);

    // Configuration registers.
    logic [LEN_W-1:0]    r_block_bits;
    logic [INIT_W-1:0]   r_init_blocks;
    logic [TEST_W-1:0]   r_test_blocks;

    logic [LEN_W-1:0]    len;
    logic [TEST_W-1:0]   k_eff;
    t_run_cfg            run_cfg;

    logic                front_valid;
    logic                front_ready;
    logic                ev_push;
    t_event              ev_in;
    logic                q_ready;
    logic                q_valid;
    t_event              q_head;
    logic                q_pop;
    logic                clearing;
    logic [SUM_BITS-1:0] log_sum;
    logic [TEST_W-1:0]   blocks_tested;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bits  <= LEN_W'(MIN_BLOCK_BITS);
            r_init_blocks <= INIT_W'(640);
            r_test_blocks <= TEST_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BLOCK_BITS:  r_block_bits  <= i_cfg_data[LEN_W-1:0];
                REG_INIT_BLOCKS: r_init_blocks <= i_cfg_data[INIT_W-1:0];
                REG_TEST_BLOCKS: r_test_blocks <= i_cfg_data[TEST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Block length is clamped to the supported range, and a test count of
    // zero counts as one. The sequence ends at block number Q+K.
    always_comb begin
        if (r_block_bits < LEN_W'(MIN_BLOCK_BITS)) begin
            len = LEN_W'(MIN_BLOCK_BITS);
        end else if (r_block_bits > LEN_W'(MAX_BLOCK_BITS)) begin
            len = LEN_W'(MAX_BLOCK_BITS);
        end else begin
            len = r_block_bits;
        end
    end

    assign k_eff              = (r_test_blocks == '0) ? TEST_W'(1) : r_test_blocks;
    assign run_cfg.len        = len;
    assign run_cfg.init       = r_init_blocks;
    assign run_cfg.last_index = INDEX_BITS'(r_init_blocks) + INDEX_BITS'(k_eff);

    // No byte is taken while the last-seen memory is being cleared.
    assign front_valid   = s_axis_tvalid && !clearing;
    assign s_axis_tready = front_ready && !clearing;

    mut_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (run_cfg),
        .i_valid       (front_valid),
        .o_ready       (front_ready),
        .i_byte        (s_axis_tdata),
        .i_first       (s_axis_tuser),
        .o_push        (ev_push),
        .o_event       (ev_in),
        .i_queue_ready (q_ready)
    );

    mut_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (ev_push),
        .i_data  (ev_in),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_head),
        .i_pop   (q_pop)
    );

    mut_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_k             (k_eff),
        .i_valid         (q_valid),
        .i_event         (q_head),
        .o_pop           (q_pop),
        .o_clearing      (clearing),
        .o_m_valid       (m_axis_tvalid),
        .i_m_ready       (m_axis_tready),
        .o_log_sum       (log_sum),
        .o_blocks_tested (blocks_tested)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - SUM_BITS - TEST_W){1'b0}}, blocks_tested, log_sum};

endmodule

### sv/mut_front.sv
// ----------------------------------------------------------------------------
// mut_front: byte intake and block cutting
// Shifts bytes in most significant bit first, finds block boundaries, numbers
// the blocks and hands one event per completed block to the queue.
// ----------------------------------------------------------------------------
module mut_front import mut_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_run_cfg             i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [BYTE_BITS-1:0] i_byte,
    input  logic                 i_first,
    output logic                 o_push,
    output t_event               o_event,
    input  logic                 i_queue_ready
);

    logic                 r_busy;
    logic [BYTE_BITS-1:0] r_byte;
    logic [LEFT_W-1:0]    r_left;
    t_pattern             r_shift;
    logic [LEN_W-1:0]     r_cnt;
    t_index               r_idx;
    logic                 r_done;
    logic                 r_restart;

    t_pattern             mask;
    t_pattern             sh;
    t_pattern             nxt_sh;
    logic [LEN_W-1:0]     cn;
    logic [LEN_W-1:0]     nxt_cnt;
    logic                 found;
    logic                 stop;
    t_pattern             pat;
    logic [LEFT_W-1:0]    n_left;
    logic [BYTE_IDX_W-1:0] bidx;

    t_index               cur;
    logic                 ev_test;
    logic                 ev_last;
    logic                 live;
    logic                 want_push;
    logic                 step_ok;
    logic                 byte_done;
    logic                 accept;

    // Walk the bits still held of the current byte. The first completed block
    // is reported; a second one stops the walk just before its last bit so the
    // next pass over the byte picks it up.
    always_comb begin
        mask    = ~(t_pattern'('1) << i_cfg.len);
        sh      = r_shift;
        cn      = r_cnt;
        found   = 1'b0;
        stop    = 1'b0;
        pat     = '0;
        n_left  = '0;
        nxt_sh  = '0;
        nxt_cnt = '0;
        bidx    = '0;
        for (int i = 0; i < BYTE_BITS; i++) begin
            bidx = BYTE_IDX_W'(BYTE_TOP - i);
            if ({1'b0, bidx} < r_left && !stop) begin
                nxt_cnt = cn + 1'b1;
                nxt_sh  = {sh[MAX_BLOCK_BITS-2:0], r_byte[bidx]};
                if (nxt_cnt >= i_cfg.len) begin
                    if (found) begin
                        stop   = 1'b1;
                        n_left = LEFT_W'(bidx) + LEFT_W'(1);
                    end else begin
                        found = 1'b1;
                        pat   = nxt_sh & mask;
                        sh    = '0;
                        cn    = '0;
                    end
                end else begin
                    sh = nxt_sh;
                    cn = nxt_cnt;
                end
            end
        end
    end

    assign cur       = r_idx + 1'b1;
    assign ev_test   = cur > INDEX_BITS'(i_cfg.init);
    assign ev_last   = cur >= i_cfg.last_index;
    assign live      = r_busy && !r_done;
    assign want_push = live && found;
    assign step_ok   = r_busy && (!want_push || i_queue_ready);
    assign byte_done = r_done || !stop || ev_last;
    assign o_ready   = !r_busy || (step_ok && byte_done);
    assign accept    = i_valid && o_ready;

    assign o_push        = want_push && i_queue_ready;
    assign o_event.pat   = pat;
    assign o_event.cur   = cur;
    assign o_event.flags = '{test: ev_test, last: ev_last, restart: r_restart};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_left    <= '0;
            r_shift   <= '0;
            r_cnt     <= '0;
            r_idx     <= '0;
            r_done    <= 1'b0;
            r_restart <= 1'b0;
        end else begin
            if (step_ok && live) begin
                r_shift <= sh;
                r_cnt   <= cn;
                r_left  <= n_left;
                if (found) begin
                    r_idx     <= cur;
                    r_done    <= ev_last;
                    r_restart <= 1'b0;
                end
            end
            if (step_ok && byte_done) begin
                r_busy <= 1'b0;
            end
            if (accept) begin
                r_busy <= 1'b1;
                r_left <= LEFT_W'(BYTE_BITS);
                if (i_first) begin
                    r_shift   <= '0;
                    r_cnt     <= '0;
                    r_idx     <= '0;
                    r_done    <= 1'b0;
                    r_restart <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_byte;
        end
    end

endmodule

### sv/mut_queue.sv
// ----------------------------------------------------------------------------
// mut_queue: block event queue
// Small first-in first-out buffer of block events between front and back end.
// ----------------------------------------------------------------------------
module mut_queue import mut_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_data,
    output logic   o_ready,
    output logic   o_valid,
    output t_event o_data,
    input  logic   i_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_event           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = r_count != CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### sv/mut_back.sv
// ----------------------------------------------------------------------------
// mut_back: last-seen table, fixed-point log2 and distance sum
// Read-modify-write of the last-seen table, then a leading-one stage, a
// normalize and fraction lookup stage and the saturating accumulation.
// ----------------------------------------------------------------------------
module mut_back import mut_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [TEST_W-1:0]   i_k,
    input  logic                i_valid,
    input  t_event              i_event,
    output logic                o_pop,
    output logic                o_clearing,
    output logic                o_m_valid,
    input  logic                i_m_ready,
    output logic [SUM_BITS-1:0] o_log_sum,
    output logic [TEST_W-1:0]   o_blocks_tested
);

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    t_state                      r_state;
    logic [MAX_BLOCK_BITS-1:0]   r_clr_addr;
    logic [EPOCH_BITS-1:0]       r_epoch;

    t_seen                       r_seen_mem [SEEN_DEPTH];
    t_seen                       r_rd;
    logic                        mem_we;
    t_pattern                    mem_wa;
    t_seen                       mem_wd;

    logic [LOG_FRACTION_BITS-1:0] frac_rom [LOG_TAB_SIZE];

    logic                        adv;
    logic                        wrap;
    logic                        start_clear;

    logic                        r_s1_valid;
    t_event                      r_s1;
    logic                        r_fwd;
    t_index                      r_fwd_idx;
    t_index                      seen;
    t_index                      blk_dist;

    logic                        r_s2_valid;
    t_flags                      r_s2_flags;
    t_index                      r_s2_dist;
    logic [POS_W-1:0]            s2_pos;

    logic                        r_s3_valid;
    t_flags                      r_s3_flags;
    t_index                      r_s3_dist;
    logic [POS_W-1:0]            r_s3_pos;
    logic                        r_s3_zero;
    t_index                      s3_norm;
    logic [LOG_TABLE_BITS-1:0]   s3_idx;

    logic                        r_s4_valid;
    t_flags                      r_s4_flags;
    logic [POS_W-1:0]            r_s4_pos;
    logic                        r_s4_zero;
    logic [LOG_FRACTION_BITS-1:0] r_s4_frac;
    logic [LOG_W-1:0]            logv;
    logic [SUM_BITS-1:0]         sum_base;
    logic [SUM_BITS:0]           sum_wide;
    logic [SUM_BITS-1:0]         n_sum;

    logic [SUM_BITS-1:0]         r_sum;
    logic                        r_out_valid;
    logic [SUM_BITS-1:0]         r_out_sum;
    logic [TEST_W-1:0]           r_out_k;

    for (genvar gi = 0; gi < LOG_TAB_SIZE; gi++) begin : g_frac
        assign frac_rom[gi] = frac_entry(gi);
    end

    // Everything moves unless a new result reaches the output register while
    // the previous one is still waiting there.
    assign adv         = !(r_out_valid && !i_m_ready && r_s4_valid && r_s4_flags.last);
    assign wrap        = i_event.flags.restart && (r_epoch == {EPOCH_BITS{1'b1}});
    assign start_clear = (r_state == ST_RUN) && i_valid && adv && wrap;
    assign o_pop       = (r_state == ST_RUN) && i_valid && adv && !wrap;
    assign o_clearing  = r_state == ST_CLEAR;

    // Table write: the clearing pass, or the entry of the block in stage one.
    assign mem_we = (r_state == ST_CLEAR) || r_s1_valid;
    assign mem_wa = (r_state == ST_CLEAR) ? r_clr_addr : r_s1.pat;
    assign mem_wd = (r_state == ST_CLEAR) ? '0 : t_seen'{epoch: r_epoch, idx: r_s1.cur};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_seen_mem[mem_wa] <= mem_wd;
        end
        if (o_pop) begin
            r_rd <= r_seen_mem[i_event.pat];
        end
    end

    // After a clearing pass every entry holds tag zero, so the tag restarts
    // from zero and the waiting restart event then moves it to one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_epoch    <= '0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == {MAX_BLOCK_BITS{1'b1}}) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (start_clear) begin
                        r_state <= ST_CLEAR;
                        r_epoch <= '0;
                    end
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase
            if (o_pop && i_event.flags.restart) begin
                r_epoch <= r_epoch + 1'b1;
            end
        end
    end

    // Stage one: entry from another sequence reads as zero; a write to the
    // same pattern in the cycle of the read is forwarded.
    assign seen     = r_fwd ? r_fwd_idx : ((r_rd.epoch == r_epoch) ? r_rd.idx : '0);
    assign blk_dist = r_s1.cur - seen;

    // Stage two: leading-one position.
    always_comb begin
        s2_pos = '0;
        for (int i = 0; i < INDEX_BITS; i++) begin
            if (r_s2_dist[i]) begin
                s2_pos = POS_W'(i);
            end
        end
    end

    // Stage three: bits below the leading one address the fraction table.
    assign s3_norm = r_s3_dist << (POS_W'(INDEX_BITS - 1) - r_s3_pos);
    assign s3_idx  = s3_norm[INDEX_BITS-2 -: LOG_TABLE_BITS];

    // Stage four: saturating accumulation.
    assign logv     = r_s4_zero ? '0 : {r_s4_pos, r_s4_frac};
    assign sum_base = r_s4_flags.restart ? '0 : r_sum;
    assign sum_wide = {1'b0, sum_base} + (SUM_BITS + 1)'(r_s4_flags.test ? logv : '0);
    assign n_sum    = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_ready) begin
                r_out_valid <= 1'b0;
            end
            if (adv) begin
                r_s1_valid <= o_pop;
                r_s2_valid <= r_s1_valid;
                r_s3_valid <= r_s2_valid;
                r_s4_valid <= r_s3_valid;
                if (r_s4_valid) begin
                    r_sum <= n_sum;
                    if (r_s4_flags.last) begin
                        r_out_valid <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (o_pop) begin
                r_s1      <= i_event;
                r_fwd     <= r_s1_valid && (r_s1.pat == i_event.pat) &&
                             !i_event.flags.restart;
                r_fwd_idx <= r_s1.cur;
            end
            r_s2_flags <= r_s1.flags;
            r_s2_dist  <= blk_dist;
            r_s3_flags <= r_s2_flags;
            r_s3_dist  <= r_s2_dist;
            r_s3_pos   <= s2_pos;
            r_s3_zero  <= r_s2_dist == '0;
            r_s4_flags <= r_s3_flags;
            r_s4_pos   <= r_s3_pos;
            r_s4_zero  <= r_s3_zero;
            r_s4_frac  <= frac_rom[s3_idx];
            if (r_s4_valid && r_s4_flags.last) begin
                r_out_sum <= n_sum;
                r_out_k   <= i_k;
            end
        end
    end

    assign o_m_valid       = r_out_valid;
    assign o_log_sum       = r_out_sum;
    assign o_blocks_tested = r_out_k;

endmodule
